// ===== rtl/tpp_pkg.sv =====
`timescale 1ns / 1ps

package tpp_pkg;

   localparam int NameLen     = 12;
   localparam int ValueLen    = 55;
   localparam int DashOne     = 2;
   localparam int DashTwo     = 35;
   localparam int DashThree   = 52;
   localparam int TraceDigits = 32;
   localparam int TraceSplit  = DashOne + 1 + TraceDigits / 2;

   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChDash  = 8'h2D;

   typedef enum logic [2:0] {
      MODE_SEEK  = 3'd0,
      MODE_NAME  = 3'd1,
      MODE_BLANK = 3'd2,
      MODE_VALUE = 3'd3,
      MODE_BAD   = 3'd4,
      MODE_GOOD  = 3'd5
   } scan_mode_type;

   typedef enum logic [1:0] {
      STATUS_NOT_FOUND = 2'd0,
      STATUS_VALID     = 2'd1,
      STATUS_MALFORMED = 2'd2
   } status_type;

   typedef struct packed {
      scan_mode_type scan_mode;
      logic [3:0]    name_position;
      logic [5:0]    value_position;
      logic [63:0]   trace_high_acc;
      logic [63:0]   trace_low_acc;
      logic [63:0]   span_acc;
   } scan_state_type;

   localparam scan_state_type StateReset = '{
      scan_mode:      MODE_SEEK,
      name_position:  4'd0,
      value_position: 6'd0,
      trace_high_acc: 64'd0,
      trace_low_acc:  64'd0,
      span_acc:       64'd0
   };

   // "traceparent:" one character per position
   function automatic logic [7:0] name_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h74;
         4'd1:    c = 8'h72;
         4'd2:    c = 8'h61;
         4'd3:    c = 8'h63;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h70;
         4'd6:    c = 8'h61;
         4'd7:    c = 8'h72;
         4'd8:    c = 8'h65;
         4'd9:    c = 8'h6E;
         4'd10:   c = 8'h74;
         4'd11:   c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // bit 4 set: not a hex digit
   function automatic logic [4:0] nibble_of(input logic [7:0] b);
      logic [4:0] n;
      if (b >= 8'h30 && b <= 8'h39) begin
         n = {1'b0, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         n = {1'b0, b[3:0] + 4'd9};
      end else begin
         n = 5'h10;
      end
      return n;
   endfunction

endpackage

// ===== rtl/tpp_if.sv =====
`timescale 1ns / 1ps

interface tpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] trace_id_high;
   logic [63:0] trace_id_low;
   logic [63:0] span_id;

   modport source (output valid, output status, output trace_id_high,
                   output trace_id_low, output span_id, input ready);
   modport sink (input valid, input status, input trace_id_high,
                 input trace_id_low, input span_id, output ready);
endinterface

// ===== rtl/tpp_step.sv =====
`timescale 1ns / 1ps

module tpp_step (
   input  tpp_pkg::scan_state_type cur,
   input  logic [7:0]              data_byte,
   output tpp_pkg::scan_state_type nxt
);

   logic [7:0] lower;
   logic       name_done;
   logic       blank_hit;
   logic       do_value;
   logic [5:0] pos;
   logic [4:0] nib;
   logic       hex_ok;
   logic       ok;

   assign lower     = (data_byte >= 8'h41 && data_byte <= 8'h5A) ?
                      data_byte + 8'd32 : data_byte;
   assign name_done = cur.name_position >= 4'(tpp_pkg::NameLen);
   assign blank_hit = ((cur.scan_mode == tpp_pkg::MODE_BLANK) ||
                       (cur.scan_mode == tpp_pkg::MODE_NAME && name_done)) &&
                      data_byte != tpp_pkg::ChSpace && data_byte != tpp_pkg::ChTab;
   assign do_value  = blank_hit || cur.scan_mode == tpp_pkg::MODE_VALUE;
   assign pos       = blank_hit ? 6'd0 : cur.value_position;
   assign nib       = tpp_pkg::nibble_of(data_byte);
   assign hex_ok    = !nib[4];

   always_comb begin
      if (pos < 6'(tpp_pkg::DashOne)) begin
         ok = data_byte == tpp_pkg::ChZero;
      end else if (pos == 6'(tpp_pkg::DashOne) || pos == 6'(tpp_pkg::DashTwo) ||
                   pos == 6'(tpp_pkg::DashThree)) begin
         ok = data_byte == tpp_pkg::ChDash;
      end else if (pos < 6'(tpp_pkg::DashThree)) begin
         ok = hex_ok;
      end else begin
         ok = 1'b1;
      end
   end

   always_comb begin
      nxt = cur;
      if (do_value) begin
         if (blank_hit) begin
            nxt.value_position = 6'd0;
         end
         if (!ok) begin
            nxt.scan_mode = tpp_pkg::MODE_BAD;
         end else begin
            nxt.value_position = pos + 6'd1;
            nxt.scan_mode = (pos + 6'd1 >= 6'(tpp_pkg::ValueLen)) ?
                            tpp_pkg::MODE_GOOD : tpp_pkg::MODE_VALUE;
            if (pos > 6'(tpp_pkg::DashOne) && pos < 6'(tpp_pkg::TraceSplit)) begin
               nxt.trace_high_acc = {cur.trace_high_acc[59:0], nib[3:0]};
            end else if (pos >= 6'(tpp_pkg::TraceSplit) &&
                         pos < 6'(tpp_pkg::DashTwo)) begin
               nxt.trace_low_acc = {cur.trace_low_acc[59:0], nib[3:0]};
            end else if (pos > 6'(tpp_pkg::DashTwo) && pos < 6'(tpp_pkg::DashThree)) begin
               nxt.span_acc = {cur.span_acc[59:0], nib[3:0]};
            end
         end
      end else begin
         case (cur.scan_mode)
            tpp_pkg::MODE_SEEK: begin
               if (data_byte == tpp_pkg::ChLf) begin
                  nxt.scan_mode     = tpp_pkg::MODE_NAME;
                  nxt.name_position = 4'd0;
               end
            end
            tpp_pkg::MODE_NAME: begin
               if (name_done) begin
                  nxt.scan_mode = tpp_pkg::MODE_BLANK;
               end else if (lower == tpp_pkg::name_char(cur.name_position)) begin
                  nxt.name_position = cur.name_position + 4'd1;
               end else if (data_byte == tpp_pkg::ChLf) begin
                  nxt.name_position = 4'd0;
               end else begin
                  nxt.scan_mode = tpp_pkg::MODE_SEEK;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/traceparent_header_parser_core.sv =====
`timescale 1ns / 1ps
// channel  role  beat contents
// req      sink  data_byte[7:0], last_byte
// rsp      src   status[1:0], trace_id_high[63:0], trace_id_low[63:0], span_id[63:0]
//
// One byte per cycle, unless a last byte is held by a stalled rsp; a byte is
// captured in the input register, and the result of a last beat is registered in
// the result register when that byte leaves the input register.
// Synchronous reset clears both valids and the scan state.
// A stalled rsp holds only the last byte of the next buffer; other bytes keep flowing.

module traceparent_header_parser_core (
   input logic           clock,
   input logic           reset,
   tpp_req_if.sink       req_bus,
   tpp_rsp_if.source     rsp_bus
);

   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    in_last_ff;
   logic                    advance;
   tpp_pkg::scan_state_type state_ff;
   tpp_pkg::scan_state_type state_in;
   tpp_pkg::status_type     status_in;
   logic                    rsp_valid_ff;
   tpp_pkg::status_type     status_ff;
   logic [63:0]             trace_high_ff;
   logic [63:0]             trace_low_ff;
   logic [63:0]             span_ff;

   tpp_step u_step (
      .cur       (state_ff),
      .data_byte (in_byte_ff),
      .nxt       (state_in)
   );

   assign advance       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      case (state_in.scan_mode)
         tpp_pkg::MODE_GOOD: status_in = tpp_pkg::STATUS_VALID;
         tpp_pkg::MODE_SEEK: status_in = tpp_pkg::STATUS_NOT_FOUND;
         tpp_pkg::MODE_NAME: status_in = tpp_pkg::STATUS_NOT_FOUND;
         default:            status_in = tpp_pkg::STATUS_MALFORMED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= tpp_pkg::StateReset;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff <= in_last_ff ? tpp_pkg::StateReset : state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
      if (advance && in_last_ff) begin
         status_ff <= status_in;
         if (status_in == tpp_pkg::STATUS_VALID) begin
            trace_high_ff <= state_in.trace_high_acc;
            trace_low_ff  <= state_in.trace_low_acc;
            span_ff       <= state_in.span_acc;
         end else begin
            trace_high_ff <= 64'd0;
            trace_low_ff  <= 64'd0;
            span_ff       <= 64'd0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.trace_id_high = trace_high_ff;
   assign rsp_bus.trace_id_low  = trace_low_ff;
   assign rsp_bus.span_id       = span_ff;

endmodule
